@@ rtl/sdc_pkg.sv @@
// Package for the sorted duplicate counter: field widths, capacity default,
// and the structs passed between the top level, the sorting cells and the counter.
// No dependencies.
package sdc_pkg;

    localparam int VALUE_W          = 32;
    localparam int DUP_W            = 7;
    localparam int DUP_MAX          = 127;
    localparam int MAX_ELEMENTS_DEF = 64;

    // Broadcast from the top level to every cell of the sorting chain.
    typedef struct packed {
        logic                      ins;
        logic                      drain;
        logic signed [VALUE_W-1:0] value;
    } t_cell_ctrl;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      valid;
        logic                      gt;
    } t_cell_link;

    typedef struct packed {
        logic step;
        logic clear;
    } t_cnt_ctrl;

endpackage

@@ rtl/sdc_in_if.sv @@
// Input channel of the sorted duplicate counter: one set element per transaction.
// Depends on sdc_pkg.
interface sdc_in_if;
    import sdc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

@@ rtl/sdc_out_if.sv @@
// Output channel of the sorted duplicate counter: one result per set.
// Depends on sdc_pkg.
interface sdc_out_if;
    import sdc_pkg::*;

    logic             valid;
    logic             ready;
    logic [DUP_W-1:0] dup_count;
    logic             overflow;

    modport source (output valid, output dup_count, output overflow, input ready);
    modport sink   (input valid, input dup_count, input overflow, output ready);
endinterface

@@ rtl/sdc_cell.sv @@
// One cell of the systolic insertion-sort chain.
// Depends on sdc_pkg.
module sdc_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sdc_pkg::t_cell_ctrl i_ctrl,
    input  sdc_pkg::t_cell_link i_left,
    input  sdc_pkg::t_cell_link i_right,
    output sdc_pkg::t_cell_link o_link
);
    import sdc_pkg::*;

    logic signed [VALUE_W-1:0] r_value, n_value;
    logic                      r_valid, n_valid;
    logic                      w_gt;

    // An empty cell counts as holding a value above everything, but only
    // the first empty cell (left neighbor occupied) takes part in an insert.
    assign w_gt   = r_valid && ($signed(r_value) > $signed(i_ctrl.value));
    assign o_link = '{value: r_value, valid: r_valid, gt: w_gt};

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctrl.drain) begin
            n_value = i_right.value;
            n_valid = i_right.valid;
        end else if (i_ctrl.ins && (w_gt || (!r_valid && i_left.valid))) begin
            // Either the left neighbor moves in, or the new value lands here.
            n_value = i_left.gt ? i_left.value : i_ctrl.value;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/sdc_counter.sv @@
// Duplicate counter fed by the head of the sorting chain while it drains.
// Depends on sdc_pkg.
module sdc_counter #(
    parameter int MAX_ELEMENTS = sdc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sdc_pkg::t_cnt_ctrl               i_ctrl,
    input  logic signed [sdc_pkg::VALUE_W-1:0] i_head,
    output logic [sdc_pkg::DUP_W-1:0]        o_dup_count
);
    import sdc_pkg::*;

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W = (CNT_W > DUP_W) ? CNT_W : DUP_W;

    logic signed [VALUE_W-1:0] r_prev, n_prev;
    logic                      r_prev_valid, n_prev_valid;
    logic                      r_counted, n_counted;
    logic [CNT_W-1:0]          r_count, n_count;
    logic                      w_eq;
    logic [CMP_W-1:0]          w_wide;

    assign w_eq = r_prev_valid && (i_head == r_prev);

    always_comb begin
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_counted    = r_counted;
        n_count      = r_count;
        if (i_ctrl.clear) begin
            n_prev_valid = 1'b0;
            n_counted    = 1'b0;
            n_count      = '0;
        end else if (i_ctrl.step) begin
            // The first repeat of a value also counts the element before it.
            if (w_eq) begin
                n_count = r_count + (r_counted ? CNT_W'(1) : CNT_W'(2));
            end
            n_counted    = w_eq;
            n_prev       = i_head;
            n_prev_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_counted    <= 1'b0;
            r_count      <= '0;
        end else begin
            r_prev_valid <= n_prev_valid;
            r_counted    <= n_counted;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
    end

    assign w_wide      = CMP_W'(r_count);
    assign o_dup_count = (w_wide > CMP_W'(DUP_MAX)) ? DUP_W'(DUP_MAX) : DUP_W'(w_wide);

endmodule

@@ rtl/sorted_duplicate_counter.sv @@
// Top level of the sorted duplicate counter: sorting chain, drain control and
// output register. Depends on sdc_pkg, sdc_in_if, sdc_out_if, sdc_cell, sdc_counter.
//
// Usage:
//   i_in carries one signed 32-bit element per transaction; last marks the
//   final element of a set. Each element is inserted into a chain of
//   MAX_ELEMENTS cells in the cycle it is accepted, so a set streams in at one
//   element per cycle. Elements that arrive while the chain is full are dropped
//   and the overflow flag of the set is raised.
//   After the last element the chain drains through the counter at its head,
//   one cell per cycle, and i_in.ready stays low for as long as the set
//   remains in the drain state. The result then goes to the output
//   register and the next set may start at once, even while the result waits.
//   o_out presents dup_count (saturated at 127) and overflow; the result holds
//   while o_out.ready is low, and a further set that finishes meanwhile waits
//   in the drain state until the register frees up.
//   Reset empties the chain and clears the output; no clearing pass is needed.
module sorted_duplicate_counter #(
    parameter int MAX_ELEMENTS = sdc_pkg::MAX_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sdc_in_if.sink      i_in,
    sdc_out_if.source   o_out
);
    import sdc_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;
    logic   r_out_valid, n_out_valid;
    logic [DUP_W-1:0] r_out_dup, n_out_dup;
    logic             r_out_ovf, n_out_ovf;

    t_cell_ctrl  w_ctrl;
    t_cnt_ctrl   w_cnt_ctrl;
    t_cell_link  w_link [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] w_valid_vec;
    logic [DUP_W-1:0]        w_dup_count;
    logic w_accept, w_full, w_finish;

    assign i_in.ready = (r_state == ST_LOAD);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = w_link[MAX_ELEMENTS-1].valid;
    assign w_finish   = (r_state == ST_DRAIN) && !w_link[0].valid
                        && (!r_out_valid || o_out.ready);

    assign w_ctrl.ins   = w_accept && !w_full;
    assign w_ctrl.drain = (r_state == ST_DRAIN) && w_link[0].valid;
    assign w_ctrl.value = i_in.value;

    assign w_cnt_ctrl.step  = w_ctrl.drain;
    assign w_cnt_ctrl.clear = w_finish;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ELEMENTS; gi++) begin : g_cell
            t_cell_link w_left, w_right;
            if (gi == 0) begin : g_head
                // The head cell sees an occupied neighbor that never moves in.
                assign w_left = '{value: '0, valid: 1'b1, gt: 1'b0};
            end else begin : g_mid
                assign w_left = w_link[gi-1];
            end
            if (gi == MAX_ELEMENTS - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_link[gi+1];
            end
            sdc_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[gi])
            );
            assign w_valid_vec[gi] = w_link[gi].valid;
        end
    endgenerate

    sdc_counter #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_counter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_cnt_ctrl),
        .i_head      (w_link[0].value),
        .o_dup_count (w_dup_count)
    );

    always_comb begin
        n_state     = r_state;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_dup   = r_out_dup;
        n_out_ovf   = r_out_ovf;
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (w_finish) begin
                    n_out_valid = 1'b1;
                    n_out_dup   = w_dup_count;
                    n_out_ovf   = r_ovf;
                    n_ovf       = 1'b0;
                    n_state     = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_dup <= n_out_dup;
        r_out_ovf <= n_out_ovf;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.dup_count = r_out_dup;
    assign o_out.overflow  = r_out_ovf;

    // Occupied cells always form one block starting at the head.
    a_valid_contig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec & (w_valid_vec + MAX_ELEMENTS'(1))) == '0))
        else $error("sorting chain has a gap in its occupied cells");

    // An insert adds exactly one occupied cell.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.ins |=> ($countones(w_valid_vec) == $past($countones(w_valid_vec)) + 1))
        else $error("insert did not add exactly one element to the chain");

    // A finished set leaves the chain empty for the next one.
    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (w_valid_vec == '0))
        else $error("chain not empty after the result was taken");

    // A new result only appears at the end of a drain.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && n_out_valid) |-> w_finish)
        else $error("result loaded outside the end of a drain");

endmodule

@@ tb/sdc_checker.sv @@
// Checker for the sorted duplicate counter: watches both channels, predicts the
// result of every set from its accepted elements and compares it field by field.
// Depends on sdc_pkg, sdc_in_if and sdc_out_if.
module sdc_checker
    import sdc_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sdc_in_if    i_in_mon,
    sdc_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [DUP_W-1:0] dup_count;
        logic             overflow;
    } t_set_result;

    t_value      set_sorted[$];
    logic        set_overflow;
    t_set_result expected_results[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        fail_total++;
    endtask

    // Equal values go after the ones already stored, as in the insertion chain.
    function automatic void insert_sorted(input t_value v);
        int pos;
        pos = set_sorted.size();
        while (pos > 0 && set_sorted[pos-1] > v)
            pos--;
        set_sorted.insert(pos, v);
    endfunction

    function automatic t_set_result tally_duplicates();
        t_set_result r;
        int          total;
        int          k;
        int          run;
        total = 0;
        k     = 0;
        while (k < set_sorted.size()) begin
            run = 1;
            while (k + run < set_sorted.size() && set_sorted[k+run] == set_sorted[k])
                run++;
            if (run >= 2)
                total += run;
            k += run;
        end
        if (total > DUP_MAX)
            total = DUP_MAX;
        r.dup_count = DUP_W'(total);
        r.overflow  = set_overflow;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_set_result got;
        t_set_result want;
        int          pushed;
        int          popped;
        pushed = 0;
        popped = 0;
        if (!i_rst_n) begin
            set_sorted.delete();
            set_overflow = 1'b0;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.dup_count = i_out_mon.dup_count;
                got.overflow  = i_out_mon.overflow;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none pending, dup_count",
                                    32'(got.dup_count), 32'(0));
                end else begin
                    want   = expected_results.pop_front();
                    popped = 1;
                    if (got.dup_count !== want.dup_count)
                        report_mismatch("dup_count", 32'(got.dup_count),
                                        32'(want.dup_count));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(got.overflow),
                                        32'(want.overflow));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                // A full chain drops the element, even one that closes the set.
                if (set_sorted.size() < MAX_ELEMENTS)
                    insert_sorted(i_in_mon.value);
                else
                    set_overflow = 1'b1;
                if (i_in_mon.last) begin
                    expected_results.push_back(tally_duplicates());
                    pushed = 1;
                    set_sorted.delete();
                    set_overflow = 1'b0;
                end
            end
            o_pending <= o_pending + pushed - popped;
        end
    end

endmodule

@@ tb/tb_sorted_duplicate_counter.sv @@
// Testbench top for the sorted duplicate counter: clock, reset, set stimulus,
// output back-pressure and the verdict. Depends on sdc_pkg, sdc_in_if,
// sdc_out_if, sdc_checker and the sorted_duplicate_counter RTL.
module tb_sorted_duplicate_counter;
    import sdc_pkg::*;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum int {
        STYLE_POOL,
        STYLE_WIDE,
        STYLE_CORNER
    } t_fill_style;

    localparam int     CAPACITY           = MAX_ELEMENTS_DEF;
    localparam int     ITEM_TARGET        = 1700;
    localparam int     IDLE_PCT           = 36;
    localparam int     DRAIN_CYCLES       = CAPACITY + 16;
    localparam int     CYCLE_LIMIT        = 400000;
    localparam int     HOLD_AFTER_RESULTS = 40;
    localparam int     HOLD_CYCLES        = 600;
    localparam int     QUIET_FIRST        = 1000;
    localparam int     QUIET_LAST         = 1300;
    localparam t_value VAL_MIN            = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam t_value VAL_MAX            = {1'b0, {(VALUE_W-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;
    logic quiet_stretch;
    int   fail_count;
    int   pending;
    int   items_sent;
    int   results_seen;
    int   cycle_count;

    sdc_in_if  in_ch();
    sdc_out_if out_ch();

    sorted_duplicate_counter #(.MAX_ELEMENTS(CAPACITY)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    sdc_checker #(.MAX_ELEMENTS(CAPACITY)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("sorted_duplicate_counter regression: fail");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off that lets the
    // chain fill up behind a waiting result.
    initial begin
        int   hold_left;
        logic hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        results_seen  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                results_seen++;
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES;
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (quiet_stretch) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic send_item(input t_value v, input logic lst);
        while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        in_ch.last  <= lst;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // The first edge lets the count pick up a set whose last element was just taken.
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    function automatic t_value pick_value(input t_fill_style style, input t_value base);
        case (style)
            STYLE_POOL: return base + t_value'($urandom_range(0, 3));
            STYLE_WIDE: return t_value'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    task automatic send_set(input int n, input t_fill_style style);
        t_value base;
        base = t_value'($urandom());
        for (int i = 0; i < n; i++)
            send_item(pick_value(style, base), i == n - 1);
    endtask

    initial begin
        int          sel;
        int          n;
        int          big_sets;
        logic        paused_once;
        t_fill_style style;
        big_sets       = 0;
        paused_once    = 1'b0;
        items_sent     = 0;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.value   <= '0;
        in_ch.last    <= 1'b0;
        quiet_stretch <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-element set at the most negative value.
        send_item(VAL_MIN, 1'b1);
        // Pair at the most positive value.
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MAX, 1'b1);
        // Three repeated values, including the most negative one, among mixed signs.
        send_item('0, 1'b0);
        send_item('1, 1'b0);
        send_item('0, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item('1, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(VAL_MIN, 1'b1);
        // All elements equal.
        send_item(t_value'(5), 1'b0);
        send_item(t_value'(5), 1'b0);
        send_item(t_value'(5), 1'b1);
        // Distinct values in ascending order.
        send_item(t_value'(1), 1'b0);
        send_item(t_value'(2), 1'b0);
        send_item(t_value'(3), 1'b0);
        send_item(t_value'(4), 1'b1);
        // Descending with one repeat at the two ends.
        send_item(-t_value'(5), 1'b0);
        send_item(-t_value'(6), 1'b0);
        send_item(-t_value'(7), 1'b0);
        send_item(-t_value'(5), 1'b1);
        wait_all_results();

        while (items_sent < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) begin
                n = $urandom_range(1, 12);
            end else if (sel < 90) begin
                n = $urandom_range(13, 40);
            end else begin
                // The first large sets fill the chain exactly and then overrun it by one.
                if (big_sets == 0)
                    n = CAPACITY;
                else if (big_sets == 1)
                    n = CAPACITY + 1;
                else
                    n = $urandom_range(CAPACITY - 4, CAPACITY + 6);
                big_sets++;
            end
            style = t_fill_style'($urandom_range(0, 2));
            if (!paused_once && items_sent >= ITEM_TARGET / 2) begin
                paused_once = 1'b1;
                wait_all_results();
            end
            quiet_stretch <= (items_sent >= QUIET_FIRST && items_sent < QUIET_LAST);
            send_set(n, style);
        end

        wait_all_results();
        quiet_stretch <= 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("sorted_duplicate_counter regression: pass");
        else
            $display("sorted_duplicate_counter regression: fail");
        $finish;
    end

endmodule
